@@ rtl/obb_pkg.sv @@
// obb_pkg: shared types and constants for the oriented-box overlap block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package obb_pkg;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // sub-steps run for each of the four axes
    localparam logic [2:0] SUB_TX  = 3'd0;   // acc = tx * a.x
    localparam logic [2:0] SUB_TY  = 3'd1;   // acc += ty * a.y, seed rhs
    localparam logic [2:0] SUB_H1  = 3'd2;   // rhs += h1 * |p1.a|
    localparam logic [2:0] SUB_H2  = 3'd3;   // rhs += h2 * |p2.a|
    localparam logic [2:0] SUB_CMP = 3'd4;   // exact compare

    localparam int unsigned NUM_AXES = 4;

    // controller -> datapath commands
    typedef struct packed {
        logic       load;      // capture reference box
        logic       capture;   // capture test box, clear flags
        logic       mul_go;    // run one product step
        logic [1:0] axis;      // axis under test
        logic [2:0] sub;       // sub-step within the axis
        logic       finish;    // resolve result, update reference
    } t_dp_cmd;
endpackage
`default_nettype wire

@@ rtl/obb_ctrl.sv @@
// obb_ctrl: sequencer for load and test beats.
// Depends on obb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obb_ctrl
    import obb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_fire,
    input  wire logic    i_op,
    input  wire logic    i_out_busy,
    output logic         o_in_ready,
    output logic         o_res_valid,
    output t_dp_cmd      o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic [2:0] r_sub, n_sub;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_sub   = r_sub;
        o_cmd   = '0;
        o_res_valid = 1'b0;
        o_in_ready  = 1'b0;
        o_cmd.axis  = r_axis;
        o_cmd.sub   = r_sub;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_axis  = '0;
                        n_sub   = SUB_TX;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                o_cmd.mul_go = 1'b1;
                if (r_sub == SUB_CMP) begin
                    n_sub = SUB_TX;
                    if (r_axis == 2'(NUM_AXES - 1)) begin
                        n_state = S_FIN;
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end else begin
                    n_sub = r_sub + 3'd1;
                end
            end
            S_FIN: begin
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    o_res_valid  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= '0;
            r_sub   <= SUB_TX;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_sub   <= n_sub;
        end
    end
endmodule
`default_nettype wire

@@ rtl/obb_dp.sv @@
// obb_dp: reference storage, shared multiplier and separation compare.
// Depends on obb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obb_dp
    import obb_pkg::*;
#(
    parameter int COORD_WIDTH    = 32,
    parameter int AXIS_FRAC_BITS = 14
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_dp_cmd                       i_cmd,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_prior_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_prior_y,
    input  wire logic signed [AXIS_FRAC_BITS+1:0] i_axis_u_x,
    input  wire logic signed [AXIS_FRAC_BITS+1:0] i_axis_u_y,
    input  wire logic signed [AXIS_FRAC_BITS+1:0] i_axis_v_x,
    input  wire logic signed [AXIS_FRAC_BITS+1:0] i_axis_v_y,
    input  wire logic [COORD_WIDTH-2:0]        i_half_width,
    input  wire logic [COORD_WIDTH-2:0]        i_half_height,
    input  wire logic                          i_is_trigger,
    output logic                               o_overlap,
    output logic                               o_trigger_hit,
    output logic                               o_restored,
    output logic signed [COORD_WIDTH-1:0]      o_ref_x,
    output logic signed [COORD_WIDTH-1:0]      o_ref_y
);
    localparam int AW = AXIS_FRAC_BITS + 2;
    localparam int HW = COORD_WIDTH - 1;
    localparam int TW = COORD_WIDTH + 1;          // centre difference
    localparam int DW = 2 * AW + 1;               // axis dot axis magnitude (signed sum)
    localparam int PW = TW + AW + 1;              // T dot axis (signed)
    localparam int CW = HW + DW + 3;              // compare width

    logic signed [COORD_WIDTH-1:0] r_cx, r_cy, r_px, r_py;
    logic signed [AW-1:0] r_ax [4];
    logic [HW-1:0]        r_ah [2];
    logic                 r_atrig;

    logic signed [AW-1:0] r_bx [4];
    logic [HW-1:0]        r_bh [2];
    logic                 r_btrig;
    logic signed [TW-1:0] r_tx, r_ty;

    logic signed [PW-1:0] r_acc;   // running dot product sum
    logic [CW-1:0]        r_rhs;
    logic [DW-1:0]        r_m1, r_m2;   // |p1.a|, |p2.a| for the current axis
    logic                 r_sep;

    // sub-steps per axis:
    //  TX : acc = tx*a.x
    //  TY : acc += ty*a.y, rhs = own half, latch |p1.a| and |p2.a|
    //  H1 : rhs += h1*|p1.a|    H2 : rhs += h2*|p2.a|
    //  CMP: flag separation when |acc| << frac > rhs
    logic [1:0] w_axis;
    logic [2:0] w_sub;
    assign w_axis = i_cmd.axis;
    assign w_sub  = i_cmd.sub;

    logic signed [AW-1:0] w_a0, w_a1;
    logic [HW-1:0]        w_own, w_h1, w_h2;
    logic signed [AW-1:0] w_p1x, w_p1y, w_p2x, w_p2y;
    always_comb begin
        if (!w_axis[1]) begin
            w_a0 = r_ax[{w_axis[0], 1'b0}];
            w_a1 = r_ax[{w_axis[0], 1'b1}];
            w_own = r_ah[w_axis[0]];
            w_p1x = r_bx[0]; w_p1y = r_bx[1]; w_h1 = r_bh[0];
            w_p2x = r_bx[2]; w_p2y = r_bx[3]; w_h2 = r_bh[1];
        end else begin
            w_a0 = r_bx[{w_axis[0], 1'b0}];
            w_a1 = r_bx[{w_axis[0], 1'b1}];
            w_own = r_bh[w_axis[0]];
            w_p1x = r_ax[0]; w_p1y = r_ax[1]; w_h1 = r_ah[0];
            w_p2x = r_ax[2]; w_p2y = r_ax[3]; w_h2 = r_ah[1];
        end
    end

    // axis-axis dot products are narrow; computed directly, then registered
    logic signed [DW-1:0] w_d1, w_d2;
    logic [DW-1:0]        w_m1, w_m2;
    assign w_d1 = DW'(w_p1x * w_a0) + DW'(w_p1y * w_a1);
    assign w_d2 = DW'(w_p2x * w_a0) + DW'(w_p2y * w_a1);
    assign w_m1 = w_d1[DW-1] ? DW'(-w_d1) : w_d1;
    assign w_m2 = w_d2[DW-1] ? DW'(-w_d2) : w_d2;

    // shared multiplier operands
    logic signed [TW:0]   w_ma;
    logic signed [DW:0]   w_mb;
    always_comb begin
        w_ma = '0; w_mb = '0;
        unique case (w_sub)
            SUB_TX: begin w_ma = (TW+1)'(r_tx); w_mb = (DW+1)'(w_a0); end
            SUB_TY: begin w_ma = (TW+1)'(r_ty); w_mb = (DW+1)'(w_a1); end
            SUB_H1: begin w_ma = (TW+1)'({1'b0, w_h1}); w_mb = (DW+1)'({1'b0, r_m1}); end
            SUB_H2: begin w_ma = (TW+1)'({1'b0, w_h2}); w_mb = (DW+1)'({1'b0, r_m2}); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end
    logic signed [TW+DW+1:0] w_full;
    assign w_full = w_ma * w_mb;

    logic [PW-1:0] w_absacc;
    assign w_absacc = r_acc[PW-1] ? PW'(-r_acc) : r_acc;
    logic [CW-1:0] w_lhs, w_own_s;
    assign w_lhs   = CW'(w_absacc) << AXIS_FRAC_BITS;
    assign w_own_s = CW'(w_own) << (2 * AXIS_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0; r_px <= '0; r_py <= '0;
            r_ax[0] <= '0; r_ax[1] <= '0; r_ax[2] <= '0; r_ax[3] <= '0;
            r_ah[0] <= '0; r_ah[1] <= '0;
            r_atrig <= 1'b0;
        end else if (i_cmd.load) begin
            r_cx <= i_center_x; r_cy <= i_center_y;
            r_px <= i_prior_x;  r_py <= i_prior_y;
            r_ax[0] <= i_axis_u_x; r_ax[1] <= i_axis_u_y;
            r_ax[2] <= i_axis_v_x; r_ax[3] <= i_axis_v_y;
            r_ah[0] <= i_half_width; r_ah[1] <= i_half_height;
            r_atrig <= i_is_trigger;
        end else if (i_cmd.finish && !r_sep && !(r_atrig || r_btrig)) begin
            r_cx <= r_px; r_cy <= r_py;
        end
        if (i_cmd.capture) begin
            r_bx[0] <= i_axis_u_x; r_bx[1] <= i_axis_u_y;
            r_bx[2] <= i_axis_v_x; r_bx[3] <= i_axis_v_y;
            r_bh[0] <= i_half_width; r_bh[1] <= i_half_height;
            r_btrig <= i_is_trigger;
            r_tx <= TW'(r_cx) - TW'(i_center_x);
            r_ty <= TW'(r_cy) - TW'(i_center_y);
            r_sep <= 1'b0;
        end
        if (i_cmd.mul_go) begin
            unique case (w_sub)
                SUB_TX: r_acc <= PW'(w_full);
                SUB_TY: begin
                    r_acc <= r_acc + PW'(w_full);
                    r_rhs <= w_own_s;
                    r_m1  <= w_m1;
                    r_m2  <= w_m2;
                end
                SUB_H1, SUB_H2: r_rhs <= r_rhs + CW'(w_full);
                SUB_CMP: if (w_lhs > r_rhs) r_sep <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_overlap     = !r_sep;
    assign o_trigger_hit = !r_sep && (r_atrig || r_btrig);
    assign o_restored    = !r_sep && !(r_atrig || r_btrig);
    assign o_ref_x = o_restored ? r_px : r_cx;
    assign o_ref_y = o_restored ? r_py : r_cy;
endmodule
`default_nettype wire

@@ rtl/obb_overlap_sat_2d.sv @@
// obb_overlap_sat_2d: top level of the oriented-box overlap tester.
// Depends on obb_pkg, obb_ctrl, obb_dp.
//
// A load beat (op = 0) stores the reference box and gives no result. A test
// beat (op = 1) runs 20 steps through one shared multiplier (four axes, five
// steps each: two centre-offset products, two extent products, one exact
// compare), then posts the result once the output register is free. A solid
// overlap moves the reference centre back to its stored earlier centre. The
// result sits in an output register; the next beat is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module obb_overlap_sat_2d
    import obb_pkg::*;
#(
    parameter int COORD_WIDTH    = 32,
    parameter int AXIS_FRAC_BITS = 14
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // op, center_x, center_y, prior_x, prior_y, axis_u_x, axis_u_y,
    // axis_v_x, axis_v_y, half_width, half_height, is_trigger; zero pad
    input  wire logic [8*((4*COORD_WIDTH+4*(AXIS_FRAC_BITS+2)+2*(COORD_WIDTH-1)+2+7)/8)-1:0]
                              s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // overlap, trigger_hit, position_restored, ref_x, ref_y; zero pad
    output logic [8*((2*COORD_WIDTH+3+7)/8)-1:0] m_axis_tdata
);
    localparam int CWD = COORD_WIDTH;
    localparam int AW  = AXIS_FRAC_BITS + 2;
    localparam int HW  = COORD_WIDTH - 1;
    localparam int O_CX = 1;
    localparam int O_CY = O_CX + CWD;
    localparam int O_PX = O_CY + CWD;
    localparam int O_PY = O_PX + CWD;
    localparam int O_UX = O_PY + CWD;
    localparam int O_UY = O_UX + AW;
    localparam int O_VX = O_UY + AW;
    localparam int O_VY = O_VX + AW;
    localparam int O_HW = O_VY + AW;
    localparam int O_HH = O_HW + HW;
    localparam int O_TR = O_HH + HW;
    localparam int OUT_W = $bits(m_axis_tdata);

    t_dp_cmd w_cmd;
    logic w_in_fire, w_res_valid, w_busy;
    logic w_ov, w_th, w_rs;
    logic signed [CWD-1:0] w_rx, w_ry;
    logic r_valid;
    logic [OUT_W-1:0] r_data;

    assign w_in_fire = s_axis_tvalid && s_axis_tready;
    assign w_busy    = r_valid && !m_axis_tready;

    obb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_in_fire),
        .i_op(s_axis_tdata[0]), .i_out_busy(w_busy),
        .o_in_ready(s_axis_tready), .o_res_valid(w_res_valid), .o_cmd(w_cmd)
    );

    obb_dp #(.COORD_WIDTH(COORD_WIDTH), .AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_center_x(s_axis_tdata[O_CX +: CWD]), .i_center_y(s_axis_tdata[O_CY +: CWD]),
        .i_prior_x(s_axis_tdata[O_PX +: CWD]),  .i_prior_y(s_axis_tdata[O_PY +: CWD]),
        .i_axis_u_x(s_axis_tdata[O_UX +: AW]),  .i_axis_u_y(s_axis_tdata[O_UY +: AW]),
        .i_axis_v_x(s_axis_tdata[O_VX +: AW]),  .i_axis_v_y(s_axis_tdata[O_VY +: AW]),
        .i_half_width(s_axis_tdata[O_HW +: HW]), .i_half_height(s_axis_tdata[O_HH +: HW]),
        .i_is_trigger(s_axis_tdata[O_TR]),
        .o_overlap(w_ov), .o_trigger_hit(w_th), .o_restored(w_rs),
        .o_ref_x(w_rx), .o_ref_y(w_ry)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
        if (w_res_valid) begin
            r_data <= OUT_W'({w_ry, w_rx, w_rs, w_th, w_ov});
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
endmodule
`default_nettype wire

@@ rtl/obb_checker.sv @@
// obb_checker: port-level checks for obb_overlap_sat_2d, bound to the top.
// Depends on obb_overlap_sat_2d ports only.
`timescale 1ns / 1ps
`default_nettype none
module obb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] s_lo,
    input wire logic [2:0] m_flags
);
    // a test beat blocks intake on the next cycle
    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_lo[0] |=> !s_axis_tready)
        else $error("intake open after test beat");
    // load gives no result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_lo[0] && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result after load");
    // flags consistent
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_flags[0] == (m_flags[1] || m_flags[2])) && !(m_flags[1] && m_flags[2]))
        else $error("flag mismatch");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_flags))
        else $error("result dropped");
endmodule

bind obb_overlap_sat_2d obb_checker u_obb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .s_lo(s_axis_tdata[7:0]), .m_flags(m_axis_tdata[2:0])
);
`default_nettype wire
